// ===== design/service_interval_reminder_assert.svh =====
// ---------------------------------------------------------------------------
// Service interval reminder assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ---------------------------------------------------------------------------
`ifndef SERVICE_INTERVAL_REMINDER_ASSERT_SVH
`define SERVICE_INTERVAL_REMINDER_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define SIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SIR_ASSERT(lbl, prop, msg)
`define SIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/sir_pkg.sv =====
// ---------------------------------------------------------------------------
// Service interval reminder package
// Payload types, codes and widths shared by the reminder and its arithmetic unit.
// ---------------------------------------------------------------------------
package sir_pkg;

  localparam int READ_BITS = 24;
  localparam int OPND_BITS = 24;
  localparam int MULB_BITS = OPND_BITS + 1;
  localparam int PROD_BITS = 2 * MULB_BITS;
  localparam int DUE_BITS  = 32;

  localparam logic [DUE_BITS-1:0]  DUE_CLAMP = 32'd9999999;
  localparam logic [OPND_BITS-1:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic [2:0] MODE_EVAL    = 3'd0;
  localparam logic [2:0] MODE_CLEAR   = 3'd1;
  localparam logic [2:0] MODE_PARAM   = 3'd2;
  localparam logic [2:0] MODE_RESTORE = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_CONT = 2'd1;
  localparam logic [1:0] ST_DUE  = 2'd2;

  localparam logic [1:0] CFG_USE_HOURS = 2'd0;
  localparam logic [1:0] CFG_FIRST_DUE = 2'd1;
  localparam logic [1:0] CFG_INTERVAL  = 2'd2;
  localparam logic [1:0] CFG_POPUP     = 2'd3;

  typedef enum logic {MD_MUL, MD_DIV} md_op_e;

  typedef struct packed {
    logic                 start;
    md_op_e               op;
    logic [MULB_BITS-1:0] operand;
  } sir_md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sir_md_rsp_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic [READ_BITS-1:0] odo_value;
    logic [READ_BITS-1:0] hour_value;
    logic [23:0]          restore_count;
    logic [31:0]          restore_next_due;
    logic                 done_value;
  } sir_in_t;

  typedef struct packed {
    logic [1:0]  reminder_status;
    logic [23:0] next_due_out;
    logic [23:0] count_out;
    logic        done_out;
  } sir_out_t;

endpackage

// ===== design/sir_muldiv.sv =====
// ---------------------------------------------------------------------------
// Shared multiply / divide unit
// Shift-add multiplier and restoring divider on one adder, one bit per cycle.
// ---------------------------------------------------------------------------
module sir_muldiv
  import sir_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sir_md_req_t          req_i,
  input  logic [OPND_BITS-1:0] a_i,
  output sir_md_rsp_t          rsp_o,
  output logic [MULB_BITS-1:0] quot_o,
  output logic [PROD_BITS-1:0] prod_o
);

  localparam int Steps   = MULB_BITS;
  localparam int CntBits = $clog2(Steps + 1);

  logic [MULB_BITS-1:0] hi_q, lo_q;
  md_op_e               op_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q, done_q;

  logic [MULB_BITS-1:0] shifted, op_a, op_b;
  logic [MULB_BITS:0]   sum;
  logic                 is_div;

  assign is_div  = (op_q == MD_DIV);
  assign shifted = {hi_q[MULB_BITS-2:0], lo_q[MULB_BITS-1]};
  assign op_a    = is_div ? shifted : hi_q;
  always_comb begin
    if (is_div) begin
      op_b = ~{1'b0, a_i};
    end else if (lo_q[0]) begin
      op_b = {1'b0, a_i};
    end else begin
      op_b = '0;
    end
  end
  // for divide the carry out means no borrow
  assign sum = {1'b0, op_a} + {1'b0, op_b} + {{MULB_BITS{1'b0}}, is_div};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= '0;
      lo_q   <= '0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        hi_q   <= '0;
        lo_q   <= req_i.operand;
        cnt_q  <= CntBits'(Steps);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (is_div) begin
          hi_q <= sum[MULB_BITS] ? sum[MULB_BITS-1:0] : shifted;
          lo_q <= {lo_q[MULB_BITS-2:0], sum[MULB_BITS]};
        end else begin
          hi_q <= sum[MULB_BITS:1];
          lo_q <= {sum[0], lo_q[MULB_BITS-1:1]};
        end
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = lo_q;
  assign prod_o     = {hi_q, lo_q};

endmodule

// ===== design/service_interval_reminder.sv =====
// ---------------------------------------------------------------------------
// Service interval reminder
// Event-driven service due tracker with one result per event.
// ---------------------------------------------------------------------------
// One event is taken at a time and every event returns one result holding the
// status, the next due reading (reported clamped to 9999999), the counter and
// the done flag. Clearance, restore, done writes and unused modes pass through
// the prepare and output states only. Evaluate and recompute with a reading
// past the first due need the due index from a 25-step restoring divide; an
// evaluate that consumes a pending clearance adds one or two 25-step
// multiplies. All of that runs through the one shared shift/add unit. A
// finished result waits in the output register while the next event is taken.
`include "service_interval_reminder_assert.svh"

module service_interval_reminder
  import sir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sir_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sir_out_t    out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_DECIDE, S_MUL, S_DUE, S_CHK, S_OUT
  } state_e;

  typedef enum logic [1:0] {PH_PARAM, PH_ADV1, PH_ADV2} phase_e;

  // configuration
  logic                 use_hours_q;
  logic [OPND_BITS-1:0] first_due_q, interval_q, popup_q;

  state_e               state_q;
  phase_e               phase_q;
  logic [2:0]           mode_q;
  logic [READ_BITS-1:0] cur_q;
  logic [23:0]          rcount_q;
  logic [31:0]          rnext_q;
  logic                 dval_q;
  logic                 gt_q;
  logic [MULB_BITS-1:0] idx_q;
  logic [23:0]          count_q;
  logic [DUE_BITS-1:0]  next_due_q;
  logic [1:0]           status_q;
  logic                 clear_q, done_q;
  logic                 out_valid_q;
  sir_out_t             out_q;
  sir_md_req_t          md_req_q;

  sir_md_rsp_t          md_rsp;
  logic [MULB_BITS-1:0] md_quot;
  logic [PROD_BITS-1:0] md_prod;

  function automatic logic [23:0] sat24(input logic [MULB_BITS:0] v);
    return (v > {2'b00, COUNT_MAX}) ? COUNT_MAX : v[23:0];
  endfunction

  logic [OPND_BITS-1:0] eff_int;
  logic [READ_BITS-1:0] rd_sel, diff;
  logic                 popup_hit, chk_hit;
  logic [MULB_BITS-1:0] count_ext;
  logic [1:0]           eval_st;
  logic [MULB_BITS:0]   adv_raw;
  logic [23:0]          adv_sat, count_inc;
  logic [PROD_BITS:0]   due_sum;
  logic [DUE_BITS-1:0]  due_sat;

  assign eff_int   = (interval_q == '0) ? OPND_BITS'(1) : interval_q;
  assign rd_sel    = use_hours_q ? in_data_i.hour_value : in_data_i.odo_value;
  assign diff      = cur_q - first_due_q;
  // popup tests wrap modulo 2^32
  assign popup_hit = (next_due_q - DUE_BITS'(cur_q)) <= DUE_BITS'(popup_q);
  assign chk_hit   = DUE_BITS'(cur_q) >= (next_due_q - DUE_BITS'(popup_q));
  assign count_ext = {1'b0, count_q};
  assign count_inc = sat24({2'b00, count_q} + (MULB_BITS + 1)'(1));

  always_comb begin
    if (!gt_q) begin
      eval_st = (count_q == '0 && popup_hit) ? ST_CONT : ST_NONE;
    end else if (count_ext > idx_q) begin
      eval_st = ST_NONE;
    end else if (count_ext < idx_q) begin
      eval_st = ST_DUE;
    end else begin
      eval_st = popup_hit ? ST_CONT : ST_NONE;
    end
  end

  assign adv_raw = (count_q == '0 || eval_st == ST_DUE) ? {1'b0, idx_q}
                                                        : {1'b0, idx_q} + (MULB_BITS + 1)'(1);
  assign adv_sat = sat24(adv_raw);
  assign due_sum = (PROD_BITS + 1)'(md_prod) + (PROD_BITS + 1)'(first_due_q);
  assign due_sat = (|due_sum[PROD_BITS:DUE_BITS]) ? '1 : due_sum[DUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_hours_q <= 1'b0;
      first_due_q <= '0;
      interval_q  <= OPND_BITS'(1);
      popup_q     <= '0;
      state_q     <= S_IDLE;
      phase_q     <= PH_PARAM;
      mode_q      <= MODE_EVAL;
      cur_q       <= '0;
      rcount_q    <= '0;
      rnext_q     <= '0;
      dval_q      <= 1'b0;
      gt_q        <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      next_due_q  <= '0;
      status_q    <= ST_NONE;
      clear_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      md_req_q    <= '0;
    end else begin
      md_req_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_USE_HOURS: use_hours_q <= cfg_data_i[0];
          CFG_FIRST_DUE: first_due_q <= cfg_data_i;
          CFG_INTERVAL:  interval_q  <= cfg_data_i;
          CFG_POPUP:     popup_q     <= cfg_data_i;
          default:       ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= in_data_i.mode;
            cur_q    <= rd_sel;
            rcount_q <= in_data_i.restore_count;
            rnext_q  <= in_data_i.restore_next_due;
            dval_q   <= in_data_i.done_value;
            state_q  <= S_PREP;
          end
        end
        S_PREP: begin
          state_q <= S_OUT;
          case (mode_q)
            MODE_EVAL, MODE_PARAM: begin
              gt_q <= cur_q > first_due_q;
              if (cur_q > first_due_q) begin
                md_req_q <= '{start: 1'b1, op: MD_DIV, operand: MULB_BITS'(diff)};
                state_q  <= S_DIV;
              end else begin
                idx_q   <= MULB_BITS'(1);
                state_q <= S_DECIDE;
              end
            end
            MODE_CLEAR:   clear_q <= 1'b1;
            MODE_RESTORE: begin
              count_q    <= rcount_q;
              next_due_q <= rnext_q;
            end
            MODE_DONE:    done_q <= dval_q;
            default:      ;
          endcase
        end
        S_DIV: begin
          if (md_rsp.done) begin
            idx_q   <= md_quot + MULB_BITS'(1);
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_OUT;
          if (mode_q == MODE_PARAM) begin
            count_q <= '0;
            done_q  <= 1'b1;
            if (!gt_q) begin
              next_due_q <= DUE_BITS'(first_due_q);
            end else begin
              md_req_q <= '{start: 1'b1, op: MD_MUL, operand: idx_q};
              phase_q  <= PH_PARAM;
              state_q  <= S_MUL;
            end
          end else begin
            status_q <= eval_st;
            if (eval_st != ST_NONE && clear_q) begin
              clear_q  <= 1'b0;
              done_q   <= 1'b1;
              count_q  <= adv_sat;
              md_req_q <= '{start: 1'b1, op: MD_MUL, operand: {1'b0, adv_sat}};
              phase_q  <= PH_ADV1;
              state_q  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (md_rsp.done) begin
            state_q <= S_DUE;
          end
        end
        S_DUE: begin
          next_due_q <= due_sat;
          state_q    <= (phase_q == PH_ADV1) ? S_CHK : S_OUT;
        end
        S_CHK: begin
          // already inside the popup window: move one service further
          state_q <= S_OUT;
          if (chk_hit) begin
            count_q  <= count_inc;
            md_req_q <= '{start: 1'b1, op: MD_MUL, operand: {1'b0, count_inc}};
            phase_q  <= PH_ADV2;
            state_q  <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q           <= 1'b1;
            out_q.reminder_status <= status_q;
            out_q.next_due_out    <= (next_due_q > DUE_CLAMP) ? DUE_CLAMP[23:0]
                                                              : next_due_q[23:0];
            out_q.count_out       <= count_q;
            out_q.done_out        <= done_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  sir_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req_q),
    .a_i    (eff_int),
    .rsp_o  (md_rsp),
    .quot_o (md_quot),
    .prod_o (md_prod)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SIR_ASSERT(a_busy_after_transfer, (in_valid_i && in_ready_o) |=> !in_ready_o,
              "ready right after an input transfer")
  `SIR_ASSERT(a_idle_unit_quiet, in_ready_o |-> !md_rsp.busy,
              "arithmetic unit busy while idle")
  `SIR_ASSERT(a_done_when_waiting, md_rsp.done |-> (state_q == S_DIV || state_q == S_MUL),
              "unit result with no step waiting")
  `SIR_ASSERT(a_due_clamped, out_valid_o |-> ({8'b0, out_data_o.next_due_out} <= DUE_CLAMP),
              "reported next due above clamp")
  `SIR_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_o,
                     "result valid during reset")

endmodule
